FILE: sv/uas_pkg.sv
// Shared types, codes and constants for the URL authority splitter.
`timescale 1ns / 1ps
package uas_pkg;

  localparam int unsigned MAX_URL_LEN_DFLT = 1024;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned ROLE_W = 4;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned OFS_W  = 10;

  localparam logic [PORT_W-1:0] DEFAULT_PORT_RST = 16'd4840;

  // Character codes
  localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_LBRK  = 8'h5B;
  localparam logic [CH_W-1:0] CH_RBRK  = 8'h5D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  // Character roles
  localparam logic [ROLE_W-1:0] ROLE_SCHEME    = 4'd0;
  localparam logic [ROLE_W-1:0] ROLE_SCH_COLON = 4'd1;
  localparam logic [ROLE_W-1:0] ROLE_SLASH     = 4'd2;
  localparam logic [ROLE_W-1:0] ROLE_HOST      = 4'd3;
  localparam logic [ROLE_W-1:0] ROLE_BRACKET   = 4'd4;
  localparam logic [ROLE_W-1:0] ROLE_PORT_COL  = 4'd5;
  localparam logic [ROLE_W-1:0] ROLE_PORT_CH   = 4'd6;
  localparam logic [ROLE_W-1:0] ROLE_PATH      = 4'd7;
  localparam logic [ROLE_W-1:0] ROLE_IGNORED   = 4'd8;

  // Status codes
  localparam logic [STAT_W-1:0] ST_GOOD  = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVAL = 2'd1;
  localparam logic [STAT_W-1:0] ST_LONG  = 2'd2;

  typedef enum logic [2:0] {
    PH_SCHEME,
    PH_SLASH1,
    PH_SLASH2,
    PH_HOST,
    PH_PORT,
    PH_PATH,
    PH_ERR
  } phase_t;

  typedef struct packed {
    logic [ROLE_W-1:0] role;
    logic              done_res;
    logic [STAT_W-1:0] status;
    logic [PORT_W-1:0] port_number;
    logic [OFS_W-1:0]  host_start;
    logic [OFS_W-1:0]  host_length;
    logic              has_path;
    logic [OFS_W-1:0]  path_start;
  } res_t;

endpackage

FILE: sv/uas_ifs.sv
// Valid/ready channel interfaces for URL characters and tagged results.
`timescale 1ns / 1ps
interface uas_in_if;
  import uas_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            last;

  modport source(output valid, output ch, output last, input ready);
  modport sink(input valid, input ch, input last, output ready);
endinterface

interface uas_out_if;
  import uas_pkg::*;
  logic              valid;
  logic              ready;
  logic [ROLE_W-1:0] role;
  logic              done_res;
  logic [STAT_W-1:0] status;
  logic [PORT_W-1:0] port_number;
  logic [OFS_W-1:0]  host_start;
  logic [OFS_W-1:0]  host_length;
  logic              has_path;
  logic [OFS_W-1:0]  path_start;

  modport source(output valid, output role, output done_res, output status,
                 output port_number, output host_start, output host_length,
                 output has_path, output path_start, input ready);
  modport sink(input valid, input role, input done_res, input status,
               input port_number, input host_start, input host_length,
               input has_path, input path_start, output ready);
endinterface

FILE: sv/uas_parse.sv
// Per-character parse state and tagging logic.
`timescale 1ns / 1ps
module uas_parse #(
  parameter int unsigned MAX_URL_LEN = uas_pkg::MAX_URL_LEN_DFLT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic [uas_pkg::CH_W-1:0]    ch,
  input  logic                        last,
  input  logic [uas_pkg::PORT_W-1:0]  default_port,
  output uas_pkg::res_t               res
);
  import uas_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_URL_LEN + 1);
  localparam int unsigned SUM_W = (POS_W > OFS_W) ? POS_W : OFS_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_URL_LEN);

  phase_t             phase_r, phase_nxt, ph_eff;
  logic               in_br_r, in_br_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [PORT_W-1:0]  acc_r, acc_nxt;
  logic               stop_r, stop_nxt;
  logic               pseen_r, pseen_nxt;
  logic [POS_W-1:0]   hbeg_r, hbeg_nxt;
  logic [POS_W-1:0]   hfin_r, hfin_nxt;
  logic               hopen_r, hopen_nxt;
  logic               hclose_r, hclose_nxt;
  logic [POS_W-1:0]   pbeg_r, pbeg_nxt;
  logic               pfound_r, pfound_nxt;
  logic [STAT_W-1:0]  err_r, err_nxt;

  logic               too_long, is_colon, is_slash, is_digit, open_here;
  logic [POS_W-1:0]   pos_inc;
  logic [ROLE_W-1:0]  role;
  logic [STAT_W-1:0]  err_fin;
  logic [POS_W-1:0]   len_raw;
  logic               strip;
  logic [SUM_W-1:0]   start_ext, len_ext, pbeg_ext;
  logic [PORT_W-1:0]  acc_step;

  assign too_long  = (phase_r != PH_ERR) && (pos_r >= POS_MAX);
  assign ph_eff    = too_long ? PH_ERR : phase_r;
  assign is_colon  = (ch == CH_COLON);
  assign is_slash  = (ch == CH_SLASH);
  assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign open_here = (pos_r == hbeg_r) && (ch == CH_LBRK);
  assign pos_inc   = POS_W'(pos_r + 1'b1);
  // accum * 10 + digit, mod 2^16
  assign acc_step  = PORT_W'((acc_r << 3) + (acc_r << 1) + PORT_W'(ch - CH_ZERO));

  // Next phase
  always_comb begin
    phase_nxt = ph_eff;
    unique case (ph_eff)
      PH_SCHEME: if (is_colon) phase_nxt = PH_SLASH1;
      PH_SLASH1: phase_nxt = is_slash ? PH_SLASH2 : PH_ERR;
      PH_SLASH2: phase_nxt = is_slash ? PH_HOST : PH_ERR;
      PH_HOST: begin
        if (!in_br_r && !open_here) begin
          if (is_colon)      phase_nxt = PH_PORT;
          else if (is_slash) phase_nxt = PH_PATH;
        end
      end
      PH_PORT: if (is_slash) phase_nxt = PH_PATH;
      PH_PATH: phase_nxt = PH_PATH;
      PH_ERR:  phase_nxt = PH_ERR;
      default: phase_nxt = PH_ERR;
    endcase
  end

  // Role and datapath updates
  always_comb begin
    role       = ROLE_IGNORED;
    in_br_nxt  = in_br_r;
    acc_nxt    = acc_r;
    stop_nxt   = stop_r;
    pseen_nxt  = pseen_r;
    hbeg_nxt   = hbeg_r;
    hfin_nxt   = hfin_r;
    hopen_nxt  = hopen_r;
    hclose_nxt = hclose_r;
    pbeg_nxt   = pbeg_r;
    pfound_nxt = pfound_r;
    err_nxt    = too_long ? ST_LONG : err_r;
    unique case (ph_eff)
      PH_SCHEME: role = is_colon ? ROLE_SCH_COLON : ROLE_SCHEME;
      PH_SLASH1: begin
        if (is_slash) role = ROLE_SLASH;
        else          err_nxt = ST_INVAL;
      end
      PH_SLASH2: begin
        if (is_slash) begin
          role     = ROLE_SLASH;
          hbeg_nxt = pos_inc;
          hfin_nxt = pos_inc;
        end else begin
          err_nxt = ST_INVAL;
        end
      end
      PH_HOST: begin
        if (in_br_r) begin
          hfin_nxt = pos_inc;
          if (ch == CH_RBRK) begin
            in_br_nxt  = 1'b0;
            hclose_nxt = 1'b1;
            role       = ROLE_BRACKET;
          end else begin
            hclose_nxt = 1'b0;
            role       = ROLE_HOST;
          end
        end else if (open_here) begin
          in_br_nxt  = 1'b1;
          hopen_nxt  = 1'b1;
          hclose_nxt = 1'b0;
          hfin_nxt   = pos_inc;
          role       = ROLE_BRACKET;
        end else if (is_colon) begin
          pseen_nxt = 1'b1;
          role      = ROLE_PORT_COL;
        end else if (is_slash) begin
          pfound_nxt = 1'b1;
          pbeg_nxt   = pos_r;
          role       = ROLE_PATH;
        end else begin
          hclose_nxt = (ch == CH_RBRK);
          hfin_nxt   = pos_inc;
          role       = ROLE_HOST;
        end
      end
      PH_PORT: begin
        if (is_slash) begin
          pfound_nxt = 1'b1;
          pbeg_nxt   = pos_r;
          role       = ROLE_PATH;
        end else begin
          if (!stop_r && is_digit) acc_nxt  = acc_step;
          else                     stop_nxt = 1'b1;
          role = ROLE_PORT_CH;
        end
      end
      PH_PATH: role = ROLE_PATH;
      PH_ERR:  role = ROLE_IGNORED;
      default: role = ROLE_IGNORED;
    endcase
    pos_nxt = (pos_r < POS_MAX) ? pos_inc : pos_r;
  end

  // Summary on the last character
  always_comb begin
    err_fin = err_nxt;
    if (err_nxt == ST_GOOD && (phase_nxt == PH_SCHEME || phase_nxt == PH_SLASH1 ||
                               phase_nxt == PH_SLASH2)) begin
      err_fin = ST_INVAL;
    end
    len_raw   = hfin_nxt - hbeg_nxt;
    strip     = (len_raw >= POS_W'(2)) && hopen_nxt && hclose_nxt;
    start_ext = SUM_W'(hbeg_nxt) + SUM_W'(strip);
    len_ext   = SUM_W'(len_raw) - (strip ? SUM_W'(2) : SUM_W'(0));
    pbeg_ext  = SUM_W'(pbeg_nxt);

    res             = '0;
    res.role        = role;
    res.done_res    = last;
    if (last) begin
      res.status = err_fin;
      if (err_fin == ST_GOOD) begin
        res.port_number = pseen_nxt ? acc_nxt : default_port;
        res.host_start  = start_ext[OFS_W-1:0];
        res.host_length = len_ext[OFS_W-1:0];
        res.has_path    = pfound_nxt;
        res.path_start  = pfound_nxt ? pbeg_ext[OFS_W-1:0] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && last)) begin
      phase_r  <= PH_SCHEME;
      in_br_r  <= 1'b0;
      pos_r    <= '0;
      acc_r    <= '0;
      stop_r   <= 1'b0;
      pseen_r  <= 1'b0;
      hbeg_r   <= '0;
      hfin_r   <= '0;
      hopen_r  <= 1'b0;
      hclose_r <= 1'b0;
      pbeg_r   <= '0;
      pfound_r <= 1'b0;
      err_r    <= ST_GOOD;
    end else if (take) begin
      phase_r  <= phase_nxt;
      in_br_r  <= in_br_nxt;
      pos_r    <= pos_nxt;
      acc_r    <= acc_nxt;
      stop_r   <= stop_nxt;
      pseen_r  <= pseen_nxt;
      hbeg_r   <= hbeg_nxt;
      hfin_r   <= hfin_nxt;
      hopen_r  <= hopen_nxt;
      hclose_r <= hclose_nxt;
      pbeg_r   <= pbeg_nxt;
      pfound_r <= pfound_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

FILE: sv/uas_out_reg.sv
// Result register with valid/ready handoff to the result channel.
`timescale 1ns / 1ps
module uas_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  uas_pkg::res_t res_in,
  input  logic          out_ready,
  output logic          can_take,
  output logic          out_valid,
  output uas_pkg::res_t res_out
);
  import uas_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  assign can_take  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

FILE: sv/url_authority_splitter_core.sv
// Top level: URL scheme/host/port/path splitter, one character per cycle.
// A character's result is registered and appears in the cycle after it is accepted.
// Throughput: one character per cycle while the sink keeps up; parse state
//   updates per character, and the result register frees as the sink takes.
// Reset (rst_n low, synchronous): parse state cleared to the scheme phase,
//   result register emptied, default_port back to 4840.
`timescale 1ns / 1ps
module url_authority_splitter_core #(
  parameter int unsigned MAX_URL_LEN = uas_pkg::MAX_URL_LEN_DFLT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  uas_in_if.sink                      in_chan,
  uas_out_if.source                   out_chan,
  input  logic                        cfg_we,
  input  logic [uas_pkg::PORT_W-1:0]  cfg_wdata
);
  import uas_pkg::*;

  logic [PORT_W-1:0] default_port_r;
  logic              take;
  logic              can_take;
  res_t              res_cur;
  res_t              res_q;

  // Configuration: default port, written only while idle: a user duty the block does not enforce
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_port_r <= DEFAULT_PORT_RST;
    end else if (cfg_we) begin
      default_port_r <= cfg_wdata;
    end
  end

  // An item enters whenever the result register is empty or being drained
  assign in_chan.ready = can_take;
  assign take          = in_chan.valid && can_take;

  // Parse state machine: tags the character and builds the URL summary
  uas_parse #(
    .MAX_URL_LEN (MAX_URL_LEN)
  ) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .ch           (in_chan.ch),
    .last         (in_chan.last),
    .default_port (default_port_r),
    .res          (res_cur)
  );

  // Result register toward the sink
  uas_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .res_in    (res_cur),
    .out_ready (out_chan.ready),
    .can_take  (can_take),
    .out_valid (out_chan.valid),
    .res_out   (res_q)
  );

  assign out_chan.role        = res_q.role;
  assign out_chan.done_res    = res_q.done_res;
  assign out_chan.status      = res_q.status;
  assign out_chan.port_number = res_q.port_number;
  assign out_chan.host_start  = res_q.host_start;
  assign out_chan.host_length = res_q.host_length;
  assign out_chan.has_path    = res_q.has_path;
  assign out_chan.path_start  = res_q.path_start;

  // Every accepted character yields a result on the next cycle
  a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_chan.valid)
    else $error("accepted item produced no result");

  // Input stalls only while a result is held back by the sink
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (out_chan.valid && !out_chan.ready))
    else $error("input stalled without a blocked result");

  // Summary fields are zero on results that are not the last character
  a_mid_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.done_res) |->
      (out_chan.status == ST_GOOD && out_chan.port_number == '0 &&
       out_chan.host_length == '0 && !out_chan.has_path))
    else $error("summary fields set on a non-final result");

  // A failed URL reports no port, host or path
  a_err_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status != ST_GOOD) |->
      (out_chan.port_number == '0 && out_chan.host_start == '0 &&
       out_chan.host_length == '0 && !out_chan.has_path &&
       out_chan.path_start == '0))
    else $error("error result carries summary data");

endmodule
